// ===== hdl/binned_weighted_time_variance_macros.svh =====
// assertion macros shared by the block's modules
`ifndef BINNED_WEIGHTED_TIME_VARIANCE_MACROS_SVH
`define BINNED_WEIGHTED_TIME_VARIANCE_MACROS_SVH

// same-cycle implication, checked out of reset
`define BWTV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BWTV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bwtv_pkg.sv =====
// types and constants of the binned weighted time variance block
package bwtv_pkg;

    // field widths
    localparam int CELL_W   = 5;
    localparam int FT_W     = 20;
    localparam int E_W      = 32;
    localparam int OFS_W    = 17;
    localparam int AXIS_W   = 16;
    localparam int HITN_W   = 11;
    localparam int BIN_W    = 7;
    localparam int SUM_W    = 48;
    localparam int MEAN_W   = 25;
    localparam int M2_W     = 63;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // time window in 1/64 ns ticks
    localparam logic [FT_W-1:0] WINDOW_TICKS = 20'd512000;
    // ceil(2^32 / 6400): bin = (ft * BIN_RECIP) >> 32, exact for 20-bit ft
    localparam logic [19:0]     BIN_RECIP    = 20'd671089;
    // rounding half for the light-path shift by 30
    localparam logic [51:0]     CORR_HALF    = 52'h0000020000000;
    localparam logic [M2_W-1:0] M2_MAX       = {M2_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX     = {SUM_W{1'b1}};

    // quotient bits of the weighted-mean divider
    localparam int DIV_STEPS = 27;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIGHT_OFFSET = 1'b0,
        CFG_LIGHT_SLOPE  = 1'b1
    } t_cfg_idx;

    // controller states
    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_BIN, S_CHK, S_DOT1, S_DOT2, S_DOT3, S_LP, S_CORR,
        S_RD, S_NEW, S_SUM, S_MDE, S_DIVI, S_DIV, S_RFIN, S_PMUL,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_UPD, S_FIN
    } t_state;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CLR, OP_BIN, OP_CHK, OP_DOT1, OP_DOT2, OP_DOT3,
        OP_LP, OP_CORR, OP_NEWW, OP_SUM, OP_MDE, OP_DIVI, OP_DIV, OP_RFIN,
        OP_PMUL, OP_P0, OP_P1, OP_P2, OP_P3, OP_P4, OP_UPD, OP_PUSH
    } t_dp_op;

    typedef struct packed {
        logic   in_ready;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic new_event;
        logic oow;
        logic clr_last;
        logic entry_valid;
        logic div_last;
        logic out_free;
    } t_dp_stat;

    // one table entry
    typedef struct packed {
        logic                valid;
        logic [HITN_W-1:0]   hitn;
        logic [SUM_W-1:0]    energy;
        logic [MEAN_W-1:0]   mean;
        logic [M2_W-1:0]     m2;
    } t_entry;

endpackage

// ===== hdl/bwtv_in_if.sv =====
// deposit channel: valid, ready and one deposit beat
interface bwtv_in_if;
    logic        valid;
    logic        ready;
    logic        new_event;
    logic [4:0]  cell_req;
    logic [19:0] flight_time;
    logic [31:0] energy;
    logic signed [16:0] offset_x;
    logic signed [16:0] offset_y;
    logic signed [16:0] offset_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;

    modport source (
        output valid, new_event, cell_req, flight_time, energy,
               offset_x, offset_y, offset_z, axis_x, axis_y, axis_z,
        input  ready
    );
    modport sink (
        input  valid, new_event, cell_req, flight_time, energy,
               offset_x, offset_y, offset_z, axis_x, axis_y, axis_z,
        output ready
    );
endinterface

// ===== hdl/bwtv_out_if.sv =====
// result channel: valid, ready and one entry report beat
interface bwtv_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] hit_number;
    logic [6:0]  time_bin;
    logic [4:0]  cell_out;
    logic        new_hit;
    logic        out_of_window;
    logic [47:0] energy_sum;
    logic signed [24:0] time_mean;
    logic [62:0] time_m2;

    modport source (
        output valid, hit_number, time_bin, cell_out, new_hit, out_of_window,
               energy_sum, time_mean, time_m2,
        input  ready
    );
    modport sink (
        input  valid, hit_number, time_bin, cell_out, new_hit, out_of_window,
               energy_sum, time_mean, time_m2,
        output ready
    );
endinterface

// ===== hdl/bwtv_dp.sv =====
// datapath: config registers, shared multiplier, divider, bin table, result register
`include "binned_weighted_time_variance_macros.svh"

module bwtv_dp #(
    parameter int NumCells    = 18,
    parameter int NumTimeBins = 80
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bwtv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bwtv_pkg::CFG_W-1:0]     i_cfg_data,
    input  bwtv_pkg::t_dp_cmd              i_cmd,
    output bwtv_pkg::t_dp_stat             o_stat,
    bwtv_in_if.sink                        i_item,
    bwtv_out_if.source                     o_result
);

    localparam int Depth = NumCells * NumTimeBins;
    localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

    // config registers
    logic [15:0] r_lo, r_ls;

    // latched deposit
    logic [4:0]         r_cell;
    logic [19:0]        r_ft;
    logic [31:0]        r_e;
    logic signed [16:0] r_ox, r_oy, r_oz;
    logic signed [15:0] r_ax, r_ay, r_az;

    // working registers
    logic signed [67:0] r_prod;
    logic [7:0]         r_bin;
    logic [IdxW-1:0]    r_idx;
    logic [IdxW-1:0]    r_clr;
    logic signed [34:0] r_dot;
    logic signed [24:0] r_t;
    logic [10:0]        r_hitcnt;
    bwtv_pkg::t_entry   r_rd;
    logic [47:0]        r_s;
    logic               r_szero;
    logic signed [25:0] r_delta;
    logic [25:0]        r_absd;
    logic [47:0]        r_rem;
    logic [26:0]        r_dsh;
    logic [26:0]        r_q;
    logic [4:0]         r_dcnt;
    logic               r_nsign;
    logic [24:0]        r_mean_new;
    logic [51:0]        r_p;
    logic [99:0]        r_acc;

    // staged and output result
    logic [10:0] r_rs_hitn;
    logic [6:0]  r_rs_bin;
    logic        r_rs_new, r_rs_oow;
    logic [47:0] r_rs_sum;
    logic [24:0] r_rs_mean;
    logic [62:0] r_rs_m2;
    logic        r_ovalid;
    logic [10:0] r_o_hitn;
    logic [6:0]  r_o_bin;
    logic [4:0]  r_o_cell;
    logic        r_o_new, r_o_oow;
    logic [47:0] r_o_sum;
    logic [24:0] r_o_mean;
    logic [62:0] r_o_m2;

    // bin table
    bwtv_pkg::t_entry r_mem [Depth];

    logic signed [33:0] w_ma, w_mb;
    logic [7:0]         w_bin;
    logic               w_oow;
    logic signed [34:0] w_lp;
    logic [67:0]        w_pmag;
    logic [21:0]        w_cq;
    logic signed [24:0] w_corr;
    logic [48:0]        w_s49;
    logic signed [25:0] w_delta;
    logic [58:0]        w_dn;
    logic [48:0]        w_rem2;
    logic               w_ge;
    logic signed [27:0] w_r;
    logic [62:0]        w_inc;
    logic [63:0]        w_m2sum;
    logic [62:0]        w_m2;
    logic               w_we;
    logic [IdxW-1:0]    w_waddr;
    bwtv_pkg::t_entry   w_wdata;

    // bin, window check and light path
    always_comb begin
        w_bin  = r_prod[39:32];
        w_oow  = (r_ft >= bwtv_pkg::WINDOW_TICKS) || (int'(w_bin) >= NumTimeBins)
                 || (int'(r_cell) >= NumCells);
        w_lp   = $signed({5'b0, r_lo, 14'b0}) - r_dot;
        w_pmag = r_prod[67] ? 68'(-r_prod) : 68'(r_prod);
        w_cq   = 22'((w_pmag[51:0] + bwtv_pkg::CORR_HALF) >> 30);
        w_corr = r_prod[67] ? -$signed({3'b0, w_cq}) : $signed({3'b0, w_cq});
    end

    // update arithmetic
    always_comb begin
        w_s49   = {1'b0, r_rd.energy} + {17'b0, r_e};
        w_delta = $signed({r_t[24], r_t}) - $signed({r_rd.mean[24], r_rd.mean});
        w_dn    = {1'b0, w_pmag[57:0]} + {12'b0, r_s[47:1]};
        w_rem2  = {r_rem, r_dsh[26]};
        w_ge    = w_rem2 >= {1'b0, r_s};
        if (r_szero) begin
            w_r = '0;
        end else if (r_nsign) begin
            w_r = -$signed({1'b0, r_q});
        end else begin
            w_r = $signed({1'b0, r_q});
        end
        w_inc   = (r_acc > 100'(bwtv_pkg::M2_MAX)) ? bwtv_pkg::M2_MAX : r_acc[62:0];
        w_m2sum = {1'b0, r_rd.m2} + {1'b0, w_inc};
        w_m2    = w_m2sum[63] ? bwtv_pkg::M2_MAX : w_m2sum[62:0];
    end

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.op)
            bwtv_pkg::OP_BIN: begin
                w_ma = $signed({14'b0, r_ft});
                w_mb = $signed({14'b0, bwtv_pkg::BIN_RECIP});
            end
            bwtv_pkg::OP_CHK: begin
                w_ma = 34'(r_ox);
                w_mb = 34'(r_ax);
            end
            bwtv_pkg::OP_DOT1: begin
                w_ma = 34'(r_oy);
                w_mb = 34'(r_ay);
            end
            bwtv_pkg::OP_DOT2: begin
                w_ma = 34'(r_oz);
                w_mb = 34'(r_az);
            end
            bwtv_pkg::OP_LP: begin
                w_ma = $signed({18'b0, r_ls});
                w_mb = w_lp[33:0];
            end
            bwtv_pkg::OP_MDE: begin
                w_ma = 34'(r_delta);
                w_mb = $signed({2'b0, r_e});
            end
            bwtv_pkg::OP_PMUL: begin
                w_ma = $signed({8'b0, r_absd});
                w_mb = r_szero ? '0 : $signed({7'b0, r_q});
            end
            bwtv_pkg::OP_P0: begin
                w_ma = $signed({10'b0, r_rd.energy[23:0]});
                w_mb = $signed({8'b0, r_prod[25:0]});
            end
            bwtv_pkg::OP_P1: begin
                w_ma = $signed({10'b0, r_rd.energy[23:0]});
                w_mb = $signed({8'b0, r_p[51:26]});
            end
            bwtv_pkg::OP_P2: begin
                w_ma = $signed({10'b0, r_rd.energy[47:24]});
                w_mb = $signed({8'b0, r_p[25:0]});
            end
            bwtv_pkg::OP_P3: begin
                w_ma = $signed({10'b0, r_rd.energy[47:24]});
                w_mb = $signed({8'b0, r_p[51:26]});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // table write select
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = '0;
        unique case (i_cmd.op)
            bwtv_pkg::OP_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
            end
            bwtv_pkg::OP_NEWW: begin
                w_we    = 1'b1;
                w_wdata = '{valid: 1'b1, hitn: r_hitcnt, energy: {16'b0, r_e},
                            mean: r_t, m2: '0};
            end
            bwtv_pkg::OP_UPD: begin
                w_we    = 1'b1;
                w_wdata = '{valid: 1'b1, hitn: r_rd.hitn, energy: r_s,
                            mean: r_mean_new, m2: w_m2};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // bin table port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.op == bwtv_pkg::OP_CORR) begin
            r_rd <= r_mem[r_idx];
        end
    end

    // multiplier product register
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= 16'd960;
            r_ls <= 16'd3932;
        end else if (i_cfg_we) begin
            unique case (bwtv_pkg::t_cfg_idx'(i_cfg_idx))
                bwtv_pkg::CFG_LIGHT_OFFSET: r_lo <= i_cfg_data;
                bwtv_pkg::CFG_LIGHT_SLOPE:  r_ls <= i_cfg_data;
                default:                    r_lo <= r_lo;
            endcase
        end
    end

    // control counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_dcnt   <= '0;
            r_hitcnt <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.op == bwtv_pkg::OP_CLR) begin
                r_clr <= (r_clr == IdxW'(Depth - 1)) ? '0 : r_clr + 1'b1;
            end
            if (i_cmd.op == bwtv_pkg::OP_DIVI) begin
                r_dcnt <= '0;
            end else if (i_cmd.op == bwtv_pkg::OP_DIV) begin
                r_dcnt <= r_dcnt + 1'b1;
            end
            if (i_cmd.op == bwtv_pkg::OP_LOAD && i_item.new_event) begin
                r_hitcnt <= '0;
            end else if (i_cmd.op == bwtv_pkg::OP_NEWW) begin
                r_hitcnt <= r_hitcnt + 1'b1;
            end
            if (i_cmd.op == bwtv_pkg::OP_PUSH) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working registers per step
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            bwtv_pkg::OP_LOAD: begin
                r_cell <= i_item.cell_req;
                r_ft   <= i_item.flight_time;
                r_e    <= i_item.energy;
                r_ox   <= i_item.offset_x;
                r_oy   <= i_item.offset_y;
                r_oz   <= i_item.offset_z;
                r_ax   <= i_item.axis_x;
                r_ay   <= i_item.axis_y;
                r_az   <= i_item.axis_z;
            end
            bwtv_pkg::OP_CHK: begin
                r_bin     <= w_bin;
                r_rs_hitn <= '0;
                r_rs_bin  <= '0;
                r_rs_new  <= 1'b0;
                r_rs_oow  <= 1'b1;
                r_rs_sum  <= '0;
                r_rs_mean <= '0;
                r_rs_m2   <= '0;
            end
            bwtv_pkg::OP_DOT1: begin
                r_dot <= r_prod[34:0];
                r_idx <= IdxW'(int'(r_cell) * NumTimeBins + int'(r_bin));
            end
            bwtv_pkg::OP_DOT2, bwtv_pkg::OP_DOT3: begin
                r_dot <= r_dot + r_prod[34:0];
            end
            bwtv_pkg::OP_CORR: begin
                r_t <= $signed({5'b0, r_ft}) + w_corr;
            end
            bwtv_pkg::OP_NEWW: begin
                r_rs_hitn <= r_hitcnt;
                r_rs_bin  <= r_bin[6:0];
                r_rs_new  <= 1'b1;
                r_rs_oow  <= 1'b0;
                r_rs_sum  <= {16'b0, r_e};
                r_rs_mean <= r_t;
                r_rs_m2   <= '0;
            end
            bwtv_pkg::OP_SUM: begin
                r_s     <= w_s49[48] ? bwtv_pkg::SUM_MAX : w_s49[47:0];
                r_szero <= (w_s49 == '0);
                r_delta <= w_delta;
                r_absd  <= w_delta[25] ? 26'(-w_delta) : 26'(w_delta);
            end
            bwtv_pkg::OP_DIVI: begin
                r_nsign <= r_prod[67];
                r_rem   <= {16'b0, w_dn[58:27]};
                r_dsh   <= w_dn[26:0];
                r_q     <= '0;
            end
            bwtv_pkg::OP_DIV: begin
                r_rem <= w_ge ? 48'(w_rem2 - {1'b0, r_s}) : w_rem2[47:0];
                r_dsh <= {r_dsh[25:0], 1'b0};
                r_q   <= {r_q[25:0], w_ge};
            end
            bwtv_pkg::OP_RFIN: begin
                r_mean_new <= r_rd.mean + w_r[24:0];
            end
            bwtv_pkg::OP_P0: begin
                r_p <= r_prod[51:0];
            end
            bwtv_pkg::OP_P1: begin
                r_acc <= {50'b0, r_prod[49:0]};
            end
            bwtv_pkg::OP_P2: begin
                r_acc <= r_acc + ({50'b0, r_prod[49:0]} << 26);
            end
            bwtv_pkg::OP_P3: begin
                r_acc <= r_acc + ({50'b0, r_prod[49:0]} << 24);
            end
            bwtv_pkg::OP_P4: begin
                r_acc <= r_acc + ({50'b0, r_prod[49:0]} << 50);
            end
            bwtv_pkg::OP_UPD: begin
                r_rs_hitn <= r_rd.hitn;
                r_rs_bin  <= r_bin[6:0];
                r_rs_new  <= 1'b0;
                r_rs_oow  <= 1'b0;
                r_rs_sum  <= r_s;
                r_rs_mean <= r_mean_new;
                r_rs_m2   <= w_m2;
            end
            bwtv_pkg::OP_PUSH: begin
                r_o_hitn <= r_rs_hitn;
                r_o_bin  <= r_rs_bin;
                r_o_cell <= r_cell;
                r_o_new  <= r_rs_new;
                r_o_oow  <= r_rs_oow;
                r_o_sum  <= r_rs_sum;
                r_o_mean <= r_rs_mean;
                r_o_m2   <= r_rs_m2;
            end
            default: begin
                r_p <= r_p;
            end
        endcase
    end

    // status to the controller
    always_comb begin
        o_stat.in_valid    = i_item.valid;
        o_stat.new_event   = i_item.new_event;
        o_stat.oow         = w_oow;
        o_stat.clr_last    = (r_clr == IdxW'(Depth - 1));
        o_stat.entry_valid = r_rd.valid;
        o_stat.div_last    = (r_dcnt == 5'(bwtv_pkg::DIV_STEPS - 1));
        o_stat.out_free    = !r_ovalid || o_result.ready;
    end

    // channel drive
    assign i_item.ready           = i_cmd.in_ready;
    assign o_result.valid         = r_ovalid;
    assign o_result.hit_number    = r_o_hitn;
    assign o_result.time_bin      = r_o_bin;
    assign o_result.cell_out      = r_o_cell;
    assign o_result.new_hit       = r_o_new;
    assign o_result.out_of_window = r_o_oow;
    assign o_result.energy_sum    = r_o_sum;
    assign o_result.time_mean     = r_o_mean;
    assign o_result.time_m2       = r_o_m2;

    // checks
    `BWTV_ASSERT_SAME(a_push_free, i_cmd.op == bwtv_pkg::OP_PUSH, !r_ovalid || o_result.ready, "result pushed over an untaken beat")
    `BWTV_ASSERT_NEXT(a_hit_count, i_cmd.op == bwtv_pkg::OP_NEWW, r_hitcnt == $past(r_hitcnt) + 11'd1, "hit counter did not advance on a new entry")
    `BWTV_ASSERT_SAME(a_oow_empty, r_ovalid && r_o_oow, r_o_sum == '0 && !r_o_new, "out-of-window beat carries entry data")

endmodule

// ===== hdl/bwtv_ctrl.sv =====
// controller: sequences clearing, bin lookup, mean update and result hand-off
`include "binned_weighted_time_variance_macros.svh"

module bwtv_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bwtv_pkg::t_dp_stat  i_stat,
    output bwtv_pkg::t_dp_cmd   o_cmd
);

    bwtv_pkg::t_state r_state, n_state;
    logic             r_item, n_item;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bwtv_pkg::S_CLR;
            r_item  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_item  <= n_item;
        end
    end

    // next state and commands
    always_comb begin
        n_state         = r_state;
        n_item          = r_item;
        o_cmd.in_ready  = 1'b0;
        o_cmd.op        = bwtv_pkg::OP_NONE;
        unique case (r_state)
            bwtv_pkg::S_CLR: begin
                o_cmd.op = bwtv_pkg::OP_CLR;
                if (i_stat.clr_last) begin
                    n_state = r_item ? bwtv_pkg::S_BIN : bwtv_pkg::S_IDLE;
                end
            end
            bwtv_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    o_cmd.op = bwtv_pkg::OP_LOAD;
                    n_item   = 1'b1;
                    n_state  = i_stat.new_event ? bwtv_pkg::S_CLR : bwtv_pkg::S_BIN;
                end
            end
            bwtv_pkg::S_BIN: begin
                o_cmd.op = bwtv_pkg::OP_BIN;
                n_state  = bwtv_pkg::S_CHK;
            end
            bwtv_pkg::S_CHK: begin
                o_cmd.op = bwtv_pkg::OP_CHK;
                n_state  = i_stat.oow ? bwtv_pkg::S_FIN : bwtv_pkg::S_DOT1;
            end
            bwtv_pkg::S_DOT1: begin
                o_cmd.op = bwtv_pkg::OP_DOT1;
                n_state  = bwtv_pkg::S_DOT2;
            end
            bwtv_pkg::S_DOT2: begin
                o_cmd.op = bwtv_pkg::OP_DOT2;
                n_state  = bwtv_pkg::S_DOT3;
            end
            bwtv_pkg::S_DOT3: begin
                o_cmd.op = bwtv_pkg::OP_DOT3;
                n_state  = bwtv_pkg::S_LP;
            end
            bwtv_pkg::S_LP: begin
                o_cmd.op = bwtv_pkg::OP_LP;
                n_state  = bwtv_pkg::S_CORR;
            end
            bwtv_pkg::S_CORR: begin
                o_cmd.op = bwtv_pkg::OP_CORR;
                n_state  = bwtv_pkg::S_RD;
            end
            bwtv_pkg::S_RD: begin
                n_state = i_stat.entry_valid ? bwtv_pkg::S_SUM : bwtv_pkg::S_NEW;
            end
            bwtv_pkg::S_NEW: begin
                o_cmd.op = bwtv_pkg::OP_NEWW;
                n_state  = bwtv_pkg::S_FIN;
            end
            bwtv_pkg::S_SUM: begin
                o_cmd.op = bwtv_pkg::OP_SUM;
                n_state  = bwtv_pkg::S_MDE;
            end
            bwtv_pkg::S_MDE: begin
                o_cmd.op = bwtv_pkg::OP_MDE;
                n_state  = bwtv_pkg::S_DIVI;
            end
            bwtv_pkg::S_DIVI: begin
                o_cmd.op = bwtv_pkg::OP_DIVI;
                n_state  = bwtv_pkg::S_DIV;
            end
            bwtv_pkg::S_DIV: begin
                o_cmd.op = bwtv_pkg::OP_DIV;
                if (i_stat.div_last) begin
                    n_state = bwtv_pkg::S_RFIN;
                end
            end
            bwtv_pkg::S_RFIN: begin
                o_cmd.op = bwtv_pkg::OP_RFIN;
                n_state  = bwtv_pkg::S_PMUL;
            end
            bwtv_pkg::S_PMUL: begin
                o_cmd.op = bwtv_pkg::OP_PMUL;
                n_state  = bwtv_pkg::S_P0;
            end
            bwtv_pkg::S_P0: begin
                o_cmd.op = bwtv_pkg::OP_P0;
                n_state  = bwtv_pkg::S_P1;
            end
            bwtv_pkg::S_P1: begin
                o_cmd.op = bwtv_pkg::OP_P1;
                n_state  = bwtv_pkg::S_P2;
            end
            bwtv_pkg::S_P2: begin
                o_cmd.op = bwtv_pkg::OP_P2;
                n_state  = bwtv_pkg::S_P3;
            end
            bwtv_pkg::S_P3: begin
                o_cmd.op = bwtv_pkg::OP_P3;
                n_state  = bwtv_pkg::S_P4;
            end
            bwtv_pkg::S_P4: begin
                o_cmd.op = bwtv_pkg::OP_P4;
                n_state  = bwtv_pkg::S_UPD;
            end
            bwtv_pkg::S_UPD: begin
                o_cmd.op = bwtv_pkg::OP_UPD;
                n_state  = bwtv_pkg::S_FIN;
            end
            bwtv_pkg::S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.op = bwtv_pkg::OP_PUSH;
                    n_item   = 1'b0;
                    n_state  = bwtv_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bwtv_pkg::S_IDLE;
            end
        endcase
    end

    // checks
    `BWTV_ASSERT_SAME(a_ready_no_item, o_cmd.in_ready, !r_item, "ready raised while a deposit is in work")
    `BWTV_ASSERT_NEXT(a_div_stays, r_state == bwtv_pkg::S_DIV, r_state == bwtv_pkg::S_DIV || r_state == bwtv_pkg::S_RFIN, "divider left early")
    `BWTV_ASSERT_NEXT(a_clr_stays, r_state == bwtv_pkg::S_CLR && !i_stat.clr_last, r_state == bwtv_pkg::S_CLR, "clearing pass cut short")

endmodule

// ===== hdl/binned_weighted_time_variance.sv =====
// top level of the binned weighted time variance block
//
// i_item carries one energy deposit per beat (crystal, flight time, energy,
// offset and crystal axis); o_result returns exactly one beat per deposit:
// the (crystal, 100 ns bin) entry made or updated, or an out-of-window flag.
// i_cfg_we/i_cfg_idx/i_cfg_data write light_offset (0) and light_slope (1).
// An out-of-window deposit goes from the window check to the result
// hand-off; a new entry is written after the light-path correction and
// the table read; an update of an existing entry also runs the 27-step
// serial divider for the weighted mean and the four partial products of
// the M2 term on the one shared 34x34 multiplier.
// i_item.ready rises again in the cycle after the result is pushed.
// A deposit with new_event set first runs a clearing pass over the whole
// table of NUM_CELLS*NUM_TIME_BINS entries (1440 by default), one entry a
// cycle. Reset runs the same pass before i_item.ready first rises.
// The result sits in an output register: the next deposit is taken while it
// waits; if the receiver stalls, the following deposit holds before its own
// result is pushed.
module binned_weighted_time_variance #(
    parameter int NUM_CELLS     = 18,
    parameter int NUM_TIME_BINS = 80
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bwtv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bwtv_pkg::CFG_W-1:0]     i_cfg_data,
    bwtv_in_if.sink                        i_item,
    bwtv_out_if.source                     o_result
);

    bwtv_pkg::t_dp_cmd  w_cmd;
    bwtv_pkg::t_dp_stat w_stat;

    // sequencer
    bwtv_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (w_stat),
        .o_cmd  (w_cmd)
    );

    // arithmetic and table
    bwtv_dp #(
        .NumCells   (NUM_CELLS),
        .NumTimeBins(NUM_TIME_BINS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .i_item    (i_item),
        .o_result  (o_result)
    );

endmodule

// ===== sim/tb_binned_weighted_time_variance.sv =====
// testbench of the binned weighted time variance block: directed and random deposits
`timescale 1ns / 1ps

module tb_binned_weighted_time_variance;

    localparam int N_CELLS = 18;
    localparam int N_BINS  = 80;
    localparam int N_ENTRY = N_CELLS * N_BINS;
    localparam int DRAIN_CYCLES = 3000;

    // one deposit
    typedef struct {
        bit                 new_event;
        bit [4:0]           cell_id;
        bit [19:0]          ft;
        bit [31:0]          energy;
        bit signed [16:0]   ox, oy, oz;
        bit signed [15:0]   ax, ay, az;
    } t_deposit;

    // one entry report
    typedef struct {
        bit [10:0]          hit_number;
        bit [6:0]           time_bin;
        bit [4:0]           cell_out;
        bit                 new_hit;
        bit                 oow;
        bit [47:0]          energy_sum;
        bit [24:0]          time_mean;
        bit [62:0]          time_m2;
    } t_report;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    bwtv_pkg::t_cfg_idx i_cfg_idx = bwtv_pkg::CFG_LIGHT_OFFSET;
    logic [bwtv_pkg::CFG_W-1:0] i_cfg_data = '0;

    bwtv_in_if  dep_ch ();
    bwtv_out_if rep_ch ();

    binned_weighted_time_variance i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (dep_ch.sink),
        .o_result   (rep_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    bit [15:0]        lo_reg = 16'd960;
    bit [15:0]        slope_reg = 16'd3932;
    bit               tbl_valid [N_ENTRY];
    bit [10:0]        tbl_hitn [N_ENTRY];
    bit [47:0]        tbl_sum [N_ENTRY];
    longint           tbl_mean [N_ENTRY];
    bit [62:0]        tbl_m2 [N_ENTRY];
    bit [10:0]        hit_cnt = '0;

    t_deposit pending_q [$];
    t_report  expected_q [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int n_reports = 0;
    int n_updates = 0;
    int n_oow = 0;

    // round to nearest, ties away from zero; den > 0
    function automatic longint round_div(longint num, longint unsigned den);
        longint unsigned mag, q;
        mag = num < 0 ? longint'(-num) : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    // bin the deposit and update the shadow table
    function automatic t_report bin_deposit(t_deposit d);
        t_report r;
        int unsigned bin, idx;
        longint dot, lp, t, delta, rr;
        longint unsigned old_sum, s, p, inc, m2, maxm2;
        r = '{default: 0};
        maxm2 = 64'h7FFF_FFFF_FFFF_FFFF;
        if (d.new_event) begin
            foreach (tbl_valid[k]) tbl_valid[k] = 1'b0;
            hit_cnt = '0;
        end
        r.cell_out = d.cell_id;
        bin = d.ft / 6400;
        if (d.ft >= 512000 || bin >= N_BINS || d.cell_id >= N_CELLS) begin
            r.oow = 1'b1;
            return r;
        end
        dot = longint'(d.ox) * d.ax + longint'(d.oy) * d.ay + longint'(d.oz) * d.az;
        lp = (longint'(lo_reg) <<< 14) - dot;
        t = longint'(d.ft) + round_div(longint'(slope_reg) * lp, 64'd1 << 30);
        idx = d.cell_id * N_BINS + bin;
        if (!tbl_valid[idx]) begin
            tbl_valid[idx] = 1'b1;
            tbl_hitn[idx] = hit_cnt;
            hit_cnt++;
            tbl_sum[idx] = 48'(d.energy);
            tbl_mean[idx] = t;
            tbl_m2[idx] = '0;
            r.new_hit = 1'b1;
        end else begin
            old_sum = tbl_sum[idx];
            s = old_sum + d.energy;
            if (s > 48'hFFFF_FFFF_FFFF) s = 48'hFFFF_FFFF_FFFF;
            delta = t - tbl_mean[idx];
            rr = (s != 0) ? round_div(delta * longint'(d.energy), s) : 0;
            p = longint'(delta < 0 ? -delta : delta) * longint'(rr < 0 ? -rr : rr);
            if (p != 0 && old_sum > maxm2 / p) inc = maxm2;
            else inc = old_sum * p;
            m2 = longint'(tbl_m2[idx]) + inc;
            if (m2 > maxm2) m2 = maxm2;
            tbl_sum[idx] = 48'(s);
            tbl_mean[idx] += rr;
            tbl_m2[idx] = 63'(m2);
            n_updates++;
        end
        r.hit_number = tbl_hitn[idx];
        r.time_bin = 7'(bin);
        r.energy_sum = tbl_sum[idx];
        r.time_mean = 25'(tbl_mean[idx]);
        r.time_m2 = tbl_m2[idx];
        return r;
    endfunction

    // deposit driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dep_ch.valid <= 1'b0;
        end else if (!dep_ch.valid || dep_ch.ready) begin
            if (dep_ch.valid) expected_q.push_back(bin_deposit(pending_q.pop_front()));
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                t_deposit d;
                d = pending_q[0];
                dep_ch.valid       <= 1'b1;
                dep_ch.new_event   <= d.new_event;
                dep_ch.cell_req    <= d.cell_id;
                dep_ch.flight_time <= d.ft;
                dep_ch.energy      <= d.energy;
                dep_ch.offset_x    <= d.ox;
                dep_ch.offset_y    <= d.oy;
                dep_ch.offset_z    <= d.oz;
                dep_ch.axis_x      <= d.ax;
                dep_ch.axis_y      <= d.ay;
                dep_ch.axis_z      <= d.az;
            end else begin
                dep_ch.valid <= 1'b0;
            end
        end
    end

    // report monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rep_ch.ready <= 1'b0;
        end else begin
            if (rep_ch.valid && rep_ch.ready) begin
                n_reports++;
                if (expected_q.size() == 0) begin
                    $error("report beat with nothing expected");
                    errors++;
                end else begin
                    t_report e;
                    e = expected_q.pop_front();
                    if (e.oow) n_oow++;
                    if (rep_ch.hit_number !== e.hit_number) begin
                        $error("hit_number exp %0d got %0d", e.hit_number, rep_ch.hit_number);
                        errors++;
                    end
                    if (rep_ch.time_bin !== e.time_bin) begin
                        $error("time_bin exp %0d got %0d", e.time_bin, rep_ch.time_bin);
                        errors++;
                    end
                    if (rep_ch.cell_out !== e.cell_out) begin
                        $error("cell_out exp %0d got %0d", e.cell_out, rep_ch.cell_out);
                        errors++;
                    end
                    if (rep_ch.new_hit !== e.new_hit) begin
                        $error("new_hit exp %0d got %0d", e.new_hit, rep_ch.new_hit);
                        errors++;
                    end
                    if (rep_ch.out_of_window !== e.oow) begin
                        $error("out_of_window exp %0d got %0d", e.oow, rep_ch.out_of_window);
                        errors++;
                    end
                    if (rep_ch.energy_sum !== e.energy_sum) begin
                        $error("energy_sum exp %0d got %0d", e.energy_sum, rep_ch.energy_sum);
                        errors++;
                    end
                    if (rep_ch.time_mean !== e.time_mean) begin
                        $error("time_mean exp %0d got %0d", $signed(e.time_mean),
                               $signed(rep_ch.time_mean));
                        errors++;
                    end
                    if (rep_ch.time_m2 !== e.time_m2) begin
                        $error("time_m2 exp %0d got %0d", e.time_m2, rep_ch.time_m2);
                        errors++;
                    end
                end
            end
            rep_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // random deposit; focused on few cells and bins so entries get updated
    function automatic t_deposit rand_deposit(bit wide);
        t_deposit d;
        int sel;
        d.new_event = ($urandom_range(39) == 0);
        sel = $urandom_range(19);
        if (sel == 0) d.cell_id = 5'($urandom_range(31));
        else if (wide) d.cell_id = 5'($urandom_range(N_CELLS - 1));
        else d.cell_id = 5'($urandom_range(2));
        sel = $urandom_range(19);
        if (sel == 0) d.ft = 20'($urandom);
        else if (sel == 1) d.ft = 20'($urandom_range(20'hFFFFF, 511900));
        else if (wide) d.ft = 20'($urandom_range(511999));
        else d.ft = 20'($urandom_range(3) * 6400 + $urandom_range(6399));
        sel = $urandom_range(9);
        if (sel == 0) d.energy = 32'hFFFF_FFFF - $urandom_range(3);
        else if (sel < 4) d.energy = $urandom_range(1000, 1);
        else d.energy = $urandom | 32'd1;
        if ($urandom_range(4) == 0) begin
            d.energy = $urandom;
            if (d.energy == 0) d.energy = 32'd1;
        end
        d.ox = 17'($urandom); d.oy = 17'($urandom); d.oz = 17'($urandom);
        d.ax = 16'(int'($urandom_range(32768)) - 16384);
        d.ay = 16'(int'($urandom_range(32768)) - 16384);
        d.az = 16'(int'($urandom_range(32768)) - 16384);
        return d;
    endfunction

    task automatic wait_drained();
        while (pending_q.size() != 0 || expected_q.size() != 0 || dep_ch.valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write beat, then the write port goes idle
    task automatic write_reg(bwtv_pkg::t_cfg_idx idx, bit [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bwtv_pkg::CFG_LIGHT_OFFSET) lo_reg = val;
        else slope_reg = val;
        @(posedge i_clk);
    endtask

    task automatic run_random(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) pending_q.push_back(rand_deposit($urandom_range(3) == 0));
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        t_deposit d;
        dep_ch.valid = 1'b0;
        dep_ch.new_event = 1'b0;
        dep_ch.cell_req = '0;
        dep_ch.flight_time = '0;
        dep_ch.energy = '0;
        dep_ch.offset_x = '0; dep_ch.offset_y = '0; dep_ch.offset_z = '0;
        dep_ch.axis_x = '0; dep_ch.axis_y = '0; dep_ch.axis_z = '0;
        rep_ch.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, repeated entry, window and cell edges
        d = '{new_event: 1'b1, cell_id: 5'd0, ft: 20'd0, energy: 32'd1,
              ox: 17'sd0, oy: 17'sd0, oz: 17'sd0,
              ax: 16'sd0, ay: 16'sd0, az: 16'sd16384};
        pending_q.push_back(d);
        d.new_event = 1'b0; d.energy = 32'hFFFF_FFFF; d.ft = 20'd6399;
        d.ox = 17'sh0FFFF; d.oy = -17'sd65536; d.oz = -17'sd65536;
        d.ax = 16'sd16384; d.ay = 16'sd16384; d.az = -16'sd16384;
        pending_q.push_back(d);
        d.ft = 20'd100; d.energy = 32'hFFFF_FFFF; d.ox = -17'sd65536; d.oy = 17'sh0FFFF;
        d.oz = 17'sh0FFFF; d.ax = -16'sd16384; d.ay = -16'sd16384; d.az = 16'sd16384;
        pending_q.push_back(d);
        repeat (3) pending_q.push_back(d);
        d.cell_id = 5'd17; d.ft = 20'd511999; d.energy = 32'd7;
        pending_q.push_back(d);
        d.ft = 20'd512000;
        pending_q.push_back(d);
        d.ft = 20'hFFFFF;
        pending_q.push_back(d);
        d.cell_id = 5'd18; d.ft = 20'd10;
        pending_q.push_back(d);
        d.cell_id = 5'd31;
        pending_q.push_back(d);
        d.new_event = 1'b1; d.cell_id = 5'd1; d.ft = 20'd600000;
        pending_q.push_back(d);
        d.new_event = 1'b0; d.cell_id = 5'd0; d.ft = 20'd100;
        pending_q.push_back(d);
        d.energy = 32'd1;
        pending_q.push_back(d);
        wait_drained();

        // register extremes, a random setting and the reset values
        write_reg(bwtv_pkg::CFG_LIGHT_OFFSET, 16'hFFFF);
        write_reg(bwtv_pkg::CFG_LIGHT_SLOPE, 16'hFFFF);
        run_random(60, 0, 0);
        wait_drained();
        write_reg(bwtv_pkg::CFG_LIGHT_OFFSET, 16'h0000);
        write_reg(bwtv_pkg::CFG_LIGHT_SLOPE, 16'h0000);
        run_random(60, 86, 0);
        wait_drained();
        write_reg(bwtv_pkg::CFG_LIGHT_OFFSET, 16'($urandom));
        write_reg(bwtv_pkg::CFG_LIGHT_SLOPE, 16'($urandom));
        run_random(60, 0, 86);
        wait_drained();
        write_reg(bwtv_pkg::CFG_LIGHT_OFFSET, 16'd960);
        write_reg(bwtv_pkg::CFG_LIGHT_SLOPE, 16'd3932);
        run_random(120, 35, 35);
        run_random(200, 0, 0);
        wait_drained();

        $display("covered %0d reports: %0d entry updates, %0d out of window",
                 n_reports, n_updates, n_oow);
        $display("register settings: reset, all ones, all zeros, random");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("[binned_weighted_time_variance] OK");
        end else begin
            $display("[binned_weighted_time_variance] ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("[binned_weighted_time_variance] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bwtv_pkg.sv
hdl/bwtv_in_if.sv
hdl/bwtv_out_if.sv
hdl/bwtv_dp.sv
hdl/bwtv_ctrl.sv
hdl/binned_weighted_time_variance.sv
sim/tb_binned_weighted_time_variance.sv
